@@ design/ray_box_slab_test_core_macros.svh @@
// Assertion macros shared by the checker of the ray box slab test core.
`ifndef RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_CORE_MACROS_SVH

// Checks a property at every rising clock edge while reset is low.
`define RBST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define RBST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants of the ray box slab test core
// Holds the coordinate format, the divider lane layout and the register map.
// ----------------------------------------------------------------------------
package rbst_pkg;

   // Coordinate format: signed fixed point with FRAC_BITS fraction bits.
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int THR_WIDTH   = 31;
   localparam int NUM_AXES    = 3;
   localparam int NUM_LANES   = 2 * NUM_AXES;

   // Divider widths: dividend is |bound - origin| shifted up by FRAC_BITS.
   localparam int NUMW = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int REMW = COORD_WIDTH;
   localparam int DIVW = COORD_WIDTH;

   localparam logic [COORD_WIDTH-1:0] T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // Register map, index of each register (byte address is four times this).
   localparam int CSR_ADDR_WIDTH = 5;
   localparam logic [2:0] REG_MIN_X     = 3'd0;
   localparam logic [2:0] REG_MIN_Y     = 3'd1;
   localparam logic [2:0] REG_MIN_Z     = 3'd2;
   localparam logic [2:0] REG_MAX_X     = 3'd3;
   localparam logic [2:0] REG_MAX_Y     = 3'd4;
   localparam logic [2:0] REG_MAX_Z     = 3'd5;
   localparam logic [2:0] REG_THRESHOLD = 3'd6;

   // One division in flight: partial remainder, dividend/quotient shifter, divisor.
   typedef struct packed {
      logic [REMW-1:0] rem;
      logic [NUMW-1:0] dq;
      logic [DIVW-1:0] dmag;
   } lane_type;

   typedef lane_type [NUM_LANES-1:0] lane_vec_type;

   // Per item flags that ride along with the divisions.
   typedef struct packed {
      logic [NUM_AXES-1:0]  par;
      logic                 par_miss;
      logic [NUM_LANES-1:0] neg;
   } side_type;

   typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] coord_vec_type;

endpackage

@@ design/ray_box_slab_test_core.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: ray against axis-aligned box, slab method
// Tests each ray item against the box held in the registers and returns hit.
// ----------------------------------------------------------------------------
// The core takes one ray item every cycle while the chain is not halted, and
// returns one hit item for each, in order (Q16.16 coordinates). The six slab
// divisions run as a chain of 49 restoring division cells, one quotient bit
// per cell. A stall on the result side halts the chain only when a finished
// item has nowhere to go.
module ray_box_slab_test_core (
   input  logic         clock,
   input  logic         reset,
   // Ray input items.
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x [31:0], origin_y [63:32], origin_z [95:64],
   // direction_x [127:96], direction_y [159:128], direction_z [191:160]
   input  logic [191:0] req_tdata,
   // Hit result items.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit [0], zero fill [7:1]
   output logic [7:0]   rsp_tdata,
   // Register port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [rbst_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int CW   = rbst_pkg::COORD_WIDTH;
   localparam int NUMW = rbst_pkg::NUMW;

   rbst_pkg::coord_vec_type      box_min_ff, box_max_ff;
   logic [rbst_pkg::THR_WIDTH-1:0] thr_ff;
   rbst_pkg::coord_vec_type      origin, direction;
   logic [2:0]                   csr_index;
   logic                         csr_write;
   logic                         en;
   logic                         back_valid, back_hit;
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;

   logic                         stage_valid [NUMW+1];
   rbst_pkg::lane_vec_type       stage_lanes [NUMW+1];
   rbst_pkg::side_type           stage_side  [NUMW+1];

   // Register writes complete on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= '0;
         box_max_ff <= '0;
         thr_ff     <= rbst_pkg::THR_WIDTH'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            rbst_pkg::REG_MIN_X:     box_min_ff[0] <= csr_pwdata;
            rbst_pkg::REG_MIN_Y:     box_min_ff[1] <= csr_pwdata;
            rbst_pkg::REG_MIN_Z:     box_min_ff[2] <= csr_pwdata;
            rbst_pkg::REG_MAX_X:     box_max_ff[0] <= csr_pwdata;
            rbst_pkg::REG_MAX_Y:     box_max_ff[1] <= csr_pwdata;
            rbst_pkg::REG_MAX_Z:     box_max_ff[2] <= csr_pwdata;
            rbst_pkg::REG_THRESHOLD: thr_ff <= csr_pwdata[rbst_pkg::THR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_index)
         rbst_pkg::REG_MIN_X:     csr_prdata = box_min_ff[0];
         rbst_pkg::REG_MIN_Y:     csr_prdata = box_min_ff[1];
         rbst_pkg::REG_MIN_Z:     csr_prdata = box_min_ff[2];
         rbst_pkg::REG_MAX_X:     csr_prdata = box_max_ff[0];
         rbst_pkg::REG_MAX_Y:     csr_prdata = box_max_ff[1];
         rbst_pkg::REG_MAX_Z:     csr_prdata = box_max_ff[2];
         rbst_pkg::REG_THRESHOLD: csr_prdata = {1'b0, thr_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Unpack the ray item.
   always_comb begin
      for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
         origin[a]    = req_tdata[a*CW +: CW];
         direction[a] = req_tdata[(a+rbst_pkg::NUM_AXES)*CW +: CW];
      end
   end

   // The chain moves unless a finished item is blocked by a waiting result.
   assign en         = !(back_valid && rsp_valid_ff && !rsp_tready);
   assign req_tready = en;

   rbst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_tvalid),
      .origin    (origin),
      .direction (direction),
      .box_min   (box_min_ff),
      .box_max   (box_max_ff),
      .threshold (thr_ff),
      .valid_out (stage_valid[0]),
      .lanes_out (stage_lanes[0]),
      .side_out  (stage_side[0])
   );

   for (genvar k = 0; k < NUMW; k++) begin : g_cell
      rbst_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (stage_valid[k]),
         .lanes_in  (stage_lanes[k]),
         .side_in   (stage_side[k]),
         .valid_out (stage_valid[k+1]),
         .lanes_out (stage_lanes[k+1]),
         .side_out  (stage_side[k+1])
      );
   end

   rbst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (stage_valid[NUMW]),
      .lanes_in  (stage_lanes[NUMW]),
      .side_in   (stage_side[NUMW]),
      .valid_out (back_valid),
      .hit       (back_hit)
   );

   // Output register for the result item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && back_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && back_valid) begin
         rsp_hit_ff <= back_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_hit_ff};

endmodule

@@ design/rbst_front.sv @@
// ----------------------------------------------------------------------------
// rbst_front: slab setup stage
// Classifies each axis as parallel or sloped and prepares six divisions.
// ----------------------------------------------------------------------------
module rbst_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  rbst_pkg::coord_vec_type origin,
   input  rbst_pkg::coord_vec_type direction,
   input  rbst_pkg::coord_vec_type box_min,
   input  rbst_pkg::coord_vec_type box_max,
   input  logic [rbst_pkg::THR_WIDTH-1:0] threshold,
   output logic                   valid_out,
   output rbst_pkg::lane_vec_type lanes_out,
   output rbst_pkg::side_type     side_out
);

   localparam int CW = rbst_pkg::COORD_WIDTH;

   logic                   valid_ff;
   rbst_pkg::lane_vec_type lanes_ff, lanes_in;
   rbst_pkg::side_type     side_ff, side_in;

   // Per axis: parallel test, origin range test, and both numerators.
   always_comb begin
      logic [CW-1:0] dmag;
      logic [CW:0]   num;
      logic [CW:0]   nmag;
      logic          outside;
      side_in  = '0;
      lanes_in = '0;
      for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
         dmag = direction[a][CW-1] ? (~direction[a] + 1'b1) : direction[a];
         side_in.par[a] = (direction[a] == '0) || (dmag < {1'b0, threshold});
         outside = ($signed(origin[a]) < $signed(box_min[a])) ||
                   ($signed(origin[a]) > $signed(box_max[a]));
         if (side_in.par[a] && outside) begin
            side_in.par_miss = 1'b1;
         end
         for (int b = 0; b < 2; b++) begin
            num  = (b == 0) ? ({box_min[a][CW-1], box_min[a]} - {origin[a][CW-1], origin[a]})
                            : ({box_max[a][CW-1], box_max[a]} - {origin[a][CW-1], origin[a]});
            nmag = num[CW] ? (~num + 1'b1) : num;
            side_in.neg[2*a+b]       = num[CW] ^ direction[a][CW-1];
            lanes_in[2*a+b].rem      = '0;
            lanes_in[2*a+b].dq       = {nmag, {rbst_pkg::FRAC_BITS{1'b0}}};
            lanes_in[2*a+b].dmag     = dmag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lanes_ff <= lanes_in;
         side_ff  <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign lanes_out = lanes_ff;
   assign side_out  = side_ff;

endmodule

@@ design/rbst_div_cell.sv @@
// ----------------------------------------------------------------------------
// rbst_div_cell: one restoring division step for all six lanes
// Each cell resolves one quotient bit and hands the lanes to the next cell.
// ----------------------------------------------------------------------------
module rbst_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  rbst_pkg::lane_vec_type lanes_in,
   input  rbst_pkg::side_type     side_in,
   output logic                   valid_out,
   output rbst_pkg::lane_vec_type lanes_out,
   output rbst_pkg::side_type     side_out
);

   localparam int REMW = rbst_pkg::REMW;
   localparam int NUMW = rbst_pkg::NUMW;

   logic                   valid_ff;
   rbst_pkg::lane_vec_type lanes_ff, lanes_in_next;
   rbst_pkg::side_type     side_ff;

   // Bring down the next dividend bit, subtract the divisor if it fits.
   always_comb begin
      logic [REMW:0] trial;
      logic          fits;
      lanes_in_next = lanes_in;
      for (int l = 0; l < rbst_pkg::NUM_LANES; l++) begin
         trial = {lanes_in[l].rem, lanes_in[l].dq[NUMW-1]};
         fits  = (trial >= {1'b0, lanes_in[l].dmag});
         lanes_in_next[l].rem = fits ? REMW'(trial - {1'b0, lanes_in[l].dmag})
                                     : REMW'(trial);
         lanes_in_next[l].dq  = {lanes_in[l].dq[NUMW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lanes_ff <= lanes_in_next;
         side_ff  <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign lanes_out = lanes_ff;
   assign side_out  = side_ff;

endmodule

@@ design/rbst_back.sv @@
// ----------------------------------------------------------------------------
// rbst_back: slab interval stage
// Saturates and orders the slab parameters, then narrows the hit interval.
// ----------------------------------------------------------------------------
module rbst_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  rbst_pkg::lane_vec_type lanes_in,
   input  rbst_pkg::side_type     side_in,
   output logic                   valid_out,
   output logic                   hit
);

   localparam int CW   = rbst_pkg::COORD_WIDTH;
   localparam int NUMW = rbst_pkg::NUMW;

   logic                          valid_a_ff, valid_b_ff;
   rbst_pkg::coord_vec_type       tlo_ff, tlo_in, thi_ff, thi_in;
   logic                          miss_a_ff;
   logic [CW-1:0]                 lo_ff, lo_in, hi_ff, hi_in;
   logic                          miss_b_ff;

   // Saturate each quotient to the signed range and order each axis pair.
   always_comb begin
      logic [CW-1:0] t [2];
      logic [NUMW-1:0] q;
      logic          upper_zero;
      logic          sat;
      for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
         for (int b = 0; b < 2; b++) begin
            q          = lanes_in[2*a+b].dq;
            upper_zero = (q[NUMW-1:CW] == '0);
            if (side_in.neg[2*a+b]) begin
               sat    = !upper_zero || (q[CW-1] && (q[CW-2:0] != '0));
               t[b]   = sat ? rbst_pkg::T_MIN : (~q[CW-1:0] + 1'b1);
            end else begin
               sat    = !upper_zero || q[CW-1];
               t[b]   = sat ? rbst_pkg::T_MAX : q[CW-1:0];
            end
         end
         if (side_in.par[a]) begin
            tlo_in[a] = rbst_pkg::T_MIN;
            thi_in[a] = rbst_pkg::T_MAX;
         end else if ($signed(t[0]) > $signed(t[1])) begin
            tlo_in[a] = t[1];
            thi_in[a] = t[0];
         end else begin
            tlo_in[a] = t[0];
            thi_in[a] = t[1];
         end
      end
   end

   // Entry is the latest slab entry, exit the earliest slab exit.
   always_comb begin
      lo_in = rbst_pkg::T_MIN;
      hi_in = rbst_pkg::T_MAX;
      for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
         if ($signed(tlo_ff[a]) > $signed(lo_in)) begin
            lo_in = tlo_ff[a];
         end
         if ($signed(thi_ff[a]) < $signed(hi_in)) begin
            hi_in = thi_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= valid_in;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tlo_ff    <= tlo_in;
         thi_ff    <= thi_in;
         miss_a_ff <= side_in.par_miss;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         miss_b_ff <= miss_a_ff;
      end
   end

   // A hit needs no parallel miss, a nonempty interval and a exit at or after zero.
   assign hit       = !miss_b_ff && !($signed(lo_ff) > $signed(hi_ff)) && !hi_ff[CW-1];
   assign valid_out = valid_b_ff;

endmodule

@@ design/rbst_checker.sv @@
// ----------------------------------------------------------------------------
// rbst_checker: port level checks of the ray box slab test core
// Watches the result channel and the register port over time.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_core_macros.svh"

module rbst_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [7:0]   rsp_tdata,
   input logic         csr_psel,
   input logic         csr_penable,
   input logic         csr_pwrite,
   input logic [rbst_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [31:0]  csr_pwdata,
   input logic [31:0]  csr_prdata,
   input logic         csr_pready
);

   // No result item may appear right after reset.
   `RBST_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_tvalid, "result after reset")

   // A stalled result item stays and holds its data.
   `RBST_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Only the hit bit of a result item may be set.
   `RBST_ASSERT(a_rsp_fill, clock, reset, rsp_tvalid |-> rsp_tdata[7:1] == 7'b0, "result fill bits set")

   // The input is held off only while a result item waits.
   `RBST_ASSERT(a_req_stall, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready, "input stalled without cause")

   // A write to the lower x bound reads back on the next cycle.
   `RBST_ASSERT(a_csr_readback, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[4:2] == rbst_pkg::REG_MIN_X |=> csr_paddr[4:2] != rbst_pkg::REG_MIN_X || csr_pwrite || csr_prdata == $past(csr_pwdata), "register readback mismatch")

endmodule

bind ray_box_slab_test_core rbst_checker u_rbst_checker (.*);
